[src/sqltok_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqltok_pkg
// Types, token codes, keyword table and character helpers shared by the
// statement tokenizer.
// ----------------------------------------------------------------------------
package sqltok_pkg;

    // Width of the internal position and length counters.
    localparam int POS_BITS = 16;
    localparam int OUT_BITS = 16;
    localparam int KW_COUNT = 11;

    typedef logic [POS_BITS-1:0] t_pos;
    typedef logic [OUT_BITS-1:0] t_out;

    localparam t_pos POS_MAX = '1;

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_STRING = 4'b0010,
        MODE_NUMBER = 4'b0100,
        MODE_WORD   = 4'b1000
    } t_mode;

    localparam logic [4:0] KIND_NUMBER    = 5'd11;
    localparam logic [4:0] KIND_STRING    = 5'd12;
    localparam logic [4:0] KIND_IDENT     = 5'd13;
    localparam logic [4:0] KIND_STAR      = 5'd14;
    localparam logic [4:0] KIND_COMMA     = 5'd15;
    localparam logic [4:0] KIND_LPAREN    = 5'd16;
    localparam logic [4:0] KIND_RPAREN    = 5'd17;
    localparam logic [4:0] KIND_SEMICOLON = 5'd18;
    localparam logic [4:0] KIND_EQUALS    = 5'd19;
    localparam logic [4:0] KIND_END       = 5'd20;
    localparam logic [4:0] KIND_UNKNOWN   = 5'd21;

    localparam logic [7:0] CH_QUOTE      = 8'h27;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_SEMICOLON  = 8'h3B;
    localparam logic [7:0] CH_EQUALS     = 8'h3D;

    // Keywords packed right-aligned, first character in the highest used byte.
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        48'h53454C454354,  // SELECT
        48'h494E53455254,  // INSERT
        48'h0000494E544F,  // INTO
        48'h56414C554553,  // VALUES
        48'h000046524F4D,  // FROM
        48'h005748455245,  // WHERE
        48'h435245415445,  // CREATE
        48'h005441424C45,  // TABLE
        48'h44454C455445,  // DELETE
        48'h000000494E54,  // INT
        48'h000054455854   // TEXT
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd6, 3'd6, 3'd4, 3'd6, 3'd4, 3'd5, 3'd6, 3'd5, 3'd6, 3'd3, 3'd4
    };

    typedef struct packed {
        logic [4:0] kind;
        t_out       offset;
        t_out       length;
        logic       done;
    } t_tok;

    function automatic t_pos sat_inc(input t_pos v);
        return (v == POS_MAX) ? v : v + t_pos'(1);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE;
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    // Returns KIND_UNKNOWN for bytes that are not one of the six symbols.
    function automatic logic [4:0] sym_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            CH_STAR:      k = KIND_STAR;
            CH_COMMA:     k = KIND_COMMA;
            CH_LPAREN:    k = KIND_LPAREN;
            CH_RPAREN:    k = KIND_RPAREN;
            CH_SEMICOLON: k = KIND_SEMICOLON;
            CH_EQUALS:    k = KIND_EQUALS;
            default:      k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] word_kind(input t_pos size, input logic [47:0] prefix);
        logic [4:0] k;
        k = KIND_IDENT;
        // Scan downward so the lowest matching keyword wins.
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            if (size == t_pos'(KW_LEN[i]) && prefix == KW_TEXT[i]) begin
                k = 5'(i);
            end
        end
        return k;
    endfunction

    function automatic logic [4:0] open_kind(input t_mode mode, input t_pos size,
                                             input logic [47:0] prefix);
        logic [4:0] k;
        case (mode)
            MODE_STRING: k = KIND_STRING;
            MODE_NUMBER: k = KIND_NUMBER;
            default:     k = word_kind(size, prefix);
        endcase
        return k;
    endfunction

    function automatic t_tok make_tok(input logic [4:0] kind, input t_pos offset,
                                      input t_pos length);
        t_tok t;
        t.kind   = kind;
        t.offset = t_out'(offset);
        t.length = t_out'(length);
        t.done   = 1'b0;
        return t;
    endfunction

endpackage

[src/sql_statement_tokenizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sql_statement_tokenizer
// Byte-serial SQL lexer: one statement byte per item in, tokens out as kind,
// offset and length.
// ----------------------------------------------------------------------------
// The tokenizer takes one byte per cycle unless stalled. A byte goes into an
// input register, is scanned there against the open token state, and the
// zero to three tokens it completes are written into a three-entry result
// buffer that drains one token per cycle while i_stall is low. A byte that
// yields no token never holds up the stream; one that yields tokens waits in
// the input register until the buffer is empty or its last token is taken in
// the same cycle, so a byte that yields two or three (a token closed by a
// symbol or unknown byte, or the last byte of a statement) stalls the next
// byte that yields one. o_run_done marks the last token of each byte. After
// the last byte an end token follows and the scan state is reset.
module sql_statement_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_in,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_token_kind,
    output logic [15:0] o_token_offset,
    output logic [15:0] o_token_length,
    output logic        o_run_done
);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_last;

    // Scan state.
    sqltok_pkg::t_mode r_mode;
    sqltok_pkg::t_pos  r_begin;
    sqltok_pkg::t_pos  r_size;
    logic [47:0]       r_prefix;
    sqltok_pkg::t_pos  r_pos;

    // Result buffer.
    sqltok_pkg::t_tok r_buf [3];
    logic [1:0]       r_rd;
    logic [1:0]       r_rem;

    sqltok_pkg::t_mode n_mode;
    sqltok_pkg::t_pos  n_begin;
    sqltok_pkg::t_pos  n_size;
    logic [47:0]       n_prefix;
    sqltok_pkg::t_tok  n_tok [3];
    logic [1:0]        n_cnt;

    logic in_take;
    logic out_take;
    logic buf_free;
    logic can_proc;
    logic proc;

    always_comb begin
        sqltok_pkg::t_tok tk;
        n_mode   = r_mode;
        n_begin  = r_begin;
        n_size   = r_size;
        n_prefix = r_prefix;
        n_cnt    = 2'd0;
        tk       = '0;
        n_tok[0] = '0;
        n_tok[1] = '0;
        n_tok[2] = '0;

        if (r_mode == sqltok_pkg::MODE_STRING) begin
            if (r_char == sqltok_pkg::CH_QUOTE) begin
                n_tok[n_cnt] = sqltok_pkg::make_tok(sqltok_pkg::KIND_STRING, n_begin, n_size);
                n_cnt  = n_cnt + 2'd1;
                n_mode = sqltok_pkg::MODE_IDLE;
            end else begin
                n_size = sqltok_pkg::sat_inc(n_size);
            end
        end else if (r_mode == sqltok_pkg::MODE_NUMBER && sqltok_pkg::is_digit(r_char)) begin
            n_size = sqltok_pkg::sat_inc(n_size);
        end else if (r_mode == sqltok_pkg::MODE_WORD && sqltok_pkg::is_word_char(r_char)) begin
            if (n_size < sqltok_pkg::t_pos'(6)) begin
                n_prefix = {n_prefix[39:0], sqltok_pkg::upcase(r_char)};
            end
            n_size = sqltok_pkg::sat_inc(n_size);
        end else begin
            // The byte closes any open token, then starts afresh.
            if (n_mode != sqltok_pkg::MODE_IDLE) begin
                n_tok[n_cnt] = sqltok_pkg::make_tok(
                    sqltok_pkg::open_kind(n_mode, n_size, n_prefix), n_begin, n_size);
                n_cnt = n_cnt + 2'd1;
            end
            n_mode = sqltok_pkg::MODE_IDLE;
            if (!sqltok_pkg::is_space(r_char)) begin
                if (sqltok_pkg::sym_kind(r_char) != sqltok_pkg::KIND_UNKNOWN) begin
                    n_tok[n_cnt] = sqltok_pkg::make_tok(sqltok_pkg::sym_kind(r_char), r_pos,
                                                        sqltok_pkg::t_pos'(1));
                    n_cnt = n_cnt + 2'd1;
                end else if (r_char == sqltok_pkg::CH_QUOTE) begin
                    n_mode  = sqltok_pkg::MODE_STRING;
                    n_begin = sqltok_pkg::sat_inc(r_pos);
                    n_size  = '0;
                end else if (sqltok_pkg::is_digit(r_char)) begin
                    n_mode  = sqltok_pkg::MODE_NUMBER;
                    n_begin = r_pos;
                    n_size  = sqltok_pkg::t_pos'(1);
                end else if (sqltok_pkg::is_alpha(r_char)
                             || r_char == sqltok_pkg::CH_UNDERSCORE) begin
                    n_mode   = sqltok_pkg::MODE_WORD;
                    n_begin  = r_pos;
                    n_size   = sqltok_pkg::t_pos'(1);
                    n_prefix = {40'd0, sqltok_pkg::upcase(r_char)};
                end else begin
                    n_tok[n_cnt] = sqltok_pkg::make_tok(sqltok_pkg::KIND_UNKNOWN, r_pos,
                                                        sqltok_pkg::t_pos'(1));
                    n_cnt = n_cnt + 2'd1;
                end
            end
        end

        if (r_last) begin
            if (n_mode != sqltok_pkg::MODE_IDLE) begin
                n_tok[n_cnt] = sqltok_pkg::make_tok(
                    sqltok_pkg::open_kind(n_mode, n_size, n_prefix), n_begin, n_size);
                n_cnt = n_cnt + 2'd1;
            end
            n_tok[n_cnt] = sqltok_pkg::make_tok(sqltok_pkg::KIND_END,
                                                sqltok_pkg::sat_inc(r_pos), '0);
            n_cnt = n_cnt + 2'd1;
        end

        // Flag the last token of this item.
        if (n_cnt != 2'd0) begin
            tk           = n_tok[n_cnt - 2'd1];
            tk.done      = 1'b1;
            n_tok[n_cnt - 2'd1] = tk;
        end
    end

    assign o_valid  = (r_rem != 2'd0);
    assign out_take = o_valid && !i_stall;
    assign buf_free = (r_rem == 2'd0) || (r_rem == 2'd1 && out_take);
    assign can_proc = (n_cnt == 2'd0) || buf_free;
    assign proc     = r_in_valid && can_proc;
    assign o_stall  = r_in_valid && !can_proc;
    assign in_take  = i_valid && !o_stall;

    assign o_token_kind   = r_buf[r_rd].kind;
    assign o_token_offset = r_buf[r_rd].offset;
    assign o_token_length = r_buf[r_rd].length;
    assign o_run_done     = r_buf[r_rd].done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take || o_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_char <= i_char_in;
            r_last <= i_final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= sqltok_pkg::MODE_IDLE;
            r_begin  <= '0;
            r_size   <= '0;
            r_prefix <= '0;
            r_pos    <= '0;
        end else if (proc) begin
            if (r_last) begin
                r_mode   <= sqltok_pkg::MODE_IDLE;
                r_begin  <= '0;
                r_size   <= '0;
                r_prefix <= '0;
                r_pos    <= '0;
            end else begin
                r_mode   <= n_mode;
                r_begin  <= n_begin;
                r_size   <= n_size;
                r_prefix <= n_prefix;
                r_pos    <= sqltok_pkg::sat_inc(r_pos);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 2'd0;
            r_rem <= 2'd0;
        end else if (proc && n_cnt != 2'd0) begin
            r_rd  <= 2'd0;
            r_rem <= n_cnt;
        end else if (out_take) begin
            r_rd  <= r_rd + 2'd1;
            r_rem <= r_rem - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && n_cnt != 2'd0) begin
            for (int i = 0; i < 3; i++) begin
                r_buf[i] <= n_tok[i];
            end
        end
    end

`ifndef SYNTHESIS
    // The buffered tokens never run past the last slot.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, r_rd} + {1'b0, r_rem} <= 3'd3))
        else $error("result buffer read past its last slot");

    // A byte that cannot be scanned stays in the input register unchanged.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !can_proc) |=> (r_in_valid && $stable(r_char) && $stable(r_last)))
        else $error("stalled byte lost from input register");

    // New tokens are only written once the previous ones are all delivered.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && n_cnt != 2'd0) |-> (r_rem == 2'd0 || (r_rem == 2'd1 && out_take)))
        else $error("result buffer overwritten with tokens pending");

    // The last byte of a statement clears the scan state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_last) |=> (r_pos == '0 && r_mode == sqltok_pkg::MODE_IDLE))
        else $error("scan state not cleared after final byte");

    // The last byte always yields at least the end token.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_last) |-> (n_cnt != 2'd0))
        else $error("final byte produced no end token");
`endif

endmodule
